// File: src/slpt_pkg.sv
package slpt_pkg;

  localparam int KIND_W  = 3;
  localparam int IDX_W   = 18;
  localparam int GREY_W  = 8;
  localparam int FRAME_W = 5;
  localparam int OUT_WORD_W = 16;

  localparam int FRAC_W  = 9;
  localparam int QUAL_W  = 8;
  localparam int DFR_W   = 5;
  localparam int TFR_W   = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam int DEFAULT_PIXELS    = 262144;
  localparam int DEFAULT_DATA_BITS = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input kind codes.
  localparam logic [KIND_W-1:0] KIND_INIT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_HIGH = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LOW  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CAL  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SCAN = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FRACTION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUALIFIER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_FR   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_FR  = 2'd3;

  localparam logic [FRAC_W-1:0] FRACTION_RST  = 9'd128;
  localparam logic [QUAL_W-1:0] QUALIFIER_RST = 8'd0;
  localparam logic [DFR_W-1:0]  DATA_FR_RST   = 5'd8;
  localparam logic [TFR_W-1:0]  TOTAL_FR_RST  = 6'd16;

  localparam logic [GREY_W-1:0] GREY_MAX = 8'd255;
  localparam logic [GREY_W-1:0] GREY_MIN = 8'd0;

  typedef enum logic [2:0] {
    CMD_INIT,
    CMD_HIGH,
    CMD_LOW,
    CMD_CAL,
    CMD_SCAN,
    CMD_NOP
  } slpt_cmd_e;

  // Decoded item handed from the front end to the back end.
  typedef struct packed {
    slpt_cmd_e          cmd;
    logic [GREY_W-1:0]  grey;
    logic [FRAME_W-1:0] pos;
    logic               to_data;
    logic               clear;
    logic               done;
  } slpt_item_t;

endpackage

// File: src/slpt_fifo.sv
module slpt_fifo
  import slpt_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           din_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           dout_o,
  output logic                       not_empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assign dout_o      = slots_q[rd_ptr_q];
  assign not_empty_o = (count_q != '0);
  assign count_o     = count_q;

endmodule

// File: src/slpt_front.sv
module slpt_front
  import slpt_pkg::*;
#(
  parameter int PIXELS = DEFAULT_PIXELS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [KIND_W-1:0]                     kind_i,
  input  logic [IDX_W-1:0]                      pixel_index_i,
  input  logic [GREY_W-1:0]                     grey_i,
  input  logic [FRAME_W-1:0]                    frame_index_i,
  input  logic [DFR_W-1:0]                      data_frames_i,
  input  logic [TFR_W-1:0]                      total_frames_i,
  input  logic [QCNT_W-1:0]                     queue_count_i,
  output logic                                  push_o,
  output slpt_item_t                            push_item_o,
  output logic [((PIXELS > 1) ? $clog2(PIXELS) : 1)-1:0] push_addr_o
);

  localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;

  // Stage 1: registered input.
  logic                 v1_q;
  logic [KIND_W-1:0]    kind1_q;
  logic [IDX_W-1:0]     idx1_q;
  logic [GREY_W-1:0]    grey1_q;
  logic [FRAME_W-1:0]   frame1_q;

  // Stage 2: classified item, address reduction in progress.
  logic                 v2_q;
  slpt_item_t           item2_q;
  logic [IDX_W-1:0]     idx2_q;

  slpt_item_t           item1_d;
  logic [QCNT_W:0]      credits;

  // Items in the two front stages already hold a queue slot.
  assign credits    = {1'b0, queue_count_i} + (QCNT_W+1)'(v1_q) + (QCNT_W+1)'(v2_q);
  assign in_ready_o = (credits < (QCNT_W+1)'(QUEUE_DEPTH));

  always_comb begin
    logic [9:0] rem;
    logic [9:0] sub;
    item1_d = '0;
    case (kind1_q)
      KIND_INIT: item1_d.cmd = CMD_INIT;
      KIND_HIGH: item1_d.cmd = CMD_HIGH;
      KIND_LOW:  item1_d.cmd = CMD_LOW;
      KIND_CAL:  item1_d.cmd = CMD_CAL;
      KIND_SCAN: item1_d.cmd = CMD_SCAN;
      default:   item1_d.cmd = CMD_NOP;
    endcase
    item1_d.grey = grey1_q;
    // Frame modulo data frame count, restoring one quotient bit per step.
    rem = {5'd0, frame1_q};
    for (int i = FRAME_W - 1; i >= 0; i--) begin
      sub = {5'd0, data_frames_i} << i;
      if (rem >= sub) begin
        rem = rem - sub;
      end
    end
    if (data_frames_i == '0) begin
      item1_d.pos     = frame1_q;
      item1_d.to_data = 1'b0;
    end else begin
      item1_d.pos     = rem[FRAME_W-1:0];
      item1_d.to_data = (frame1_q < data_frames_i);
    end
    item1_d.clear = (frame1_q == '0);
    item1_d.done  = (kind1_q == KIND_SCAN) && (total_frames_i != '0) &&
                    ({1'b0, frame1_q} == total_frames_i - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i && in_ready_o;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    kind1_q  <= kind_i;
    idx1_q   <= pixel_index_i;
    grey1_q  <= grey_i;
    frame1_q <= frame_index_i;
    item2_q  <= item1_d;
    idx2_q   <= idx1_q;
  end

  generate
    if (PIXELS >= (2 ** IDX_W)) begin : g_direct
      assign push_addr_o = AW'(idx2_q);
    end else begin : g_reduce
      // Index modulo PIXELS: quotient estimate by reciprocal, then one
      // correction, since the estimate is low by at most one.
      localparam int PW = 2 * IDX_W + 1;
      localparam logic [IDX_W:0] RECIP = (IDX_W+1)'((2 ** IDX_W) / PIXELS);
      localparam logic [IDX_W:0] PIX_C = (IDX_W+1)'(PIXELS);

      logic [PW-1:0]  prod;
      logic [IDX_W:0] quot_q;
      logic [IDX_W:0] qp;
      logic [IDX_W:0] diff;
      logic [IDX_W:0] rest;

      assign prod = PW'(idx1_q) * PW'(RECIP);

      always_ff @(posedge clk_i) begin
        quot_q <= prod[PW-1:IDX_W];
      end

      assign qp   = quot_q * PIX_C;
      assign diff = {1'b0, idx2_q} - qp;
      assign rest = (diff >= PIX_C) ? diff - PIX_C : diff;
      assign push_addr_o = rest[AW-1:0];
    end
  endgenerate

  assign push_o      = v2_q;
  assign push_item_o = item2_q;

endmodule

// File: src/slpt_back.sv
module slpt_back
  import slpt_pkg::*;
#(
  parameter int PIXELS        = DEFAULT_PIXELS,
  parameter int MAX_DATA_BITS = DEFAULT_DATA_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  queue_valid_i,
  output logic                                  queue_pop_o,
  input  slpt_item_t                            queue_item_i,
  input  logic [((PIXELS > 1) ? $clog2(PIXELS) : 1)-1:0] queue_addr_i,
  input  logic [FRAC_W-1:0]                     fraction_i,
  input  logic [QUAL_W-1:0]                     qualifier_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [GREY_W-1:0]                     range_out_o,
  output logic [GREY_W-1:0]                     mid_out_o,
  output logic                                  binary_bit_o,
  output logic                                  pixel_used_o,
  output logic [OUT_WORD_W-1:0]                 data_word_o,
  output logic [OUT_WORD_W-1:0]                 parity_word_o,
  output logic                                  frame_done_o
);

  localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int W  = MAX_DATA_BITS;
  // Entry layout: max, min, mid, range, data word, parity word.
  localparam int EW = 4 * GREY_W + 2 * W;

  logic [EW-1:0] mem [PIXELS];
  logic [EW-1:0] rd_data_q;

  logic          e_valid_q;
  slpt_item_t    e_item_q;
  logic [AW-1:0] e_addr_q;
  logic          e_byp_q;
  logic [EW-1:0] e_byp_data_q;

  logic          out_free;
  logic          e_fire;
  logic [EW-1:0] cur;
  logic [EW-1:0] nxt;
  logic          bit_val;

  assign out_free    = !out_valid_o || out_ready_i;
  assign e_fire      = e_valid_q && out_free;
  assign queue_pop_o = queue_valid_i && (!e_valid_q || e_fire);

  // An item read in the same cycle that its predecessor writes the same
  // pixel takes the freshly computed entry instead of the stale read.
  assign cur = e_byp_q ? e_byp_data_q : rd_data_q;

  always_comb begin
    logic [GREY_W-1:0]   c_max, c_min, c_mid, c_rng;
    logic [W-1:0]        c_dat, c_par;
    logic [GREY_W-1:0]   n_max, n_min, n_mid, n_rng;
    logic [W-1:0]        n_dat, n_par;
    logic [GREY_W-1:0]   diff;
    logic [GREY_W+FRAC_W-1:0] prod;
    logic [GREY_W+1:0]   sum;
    logic [W-1:0]        mask;
    logic                pos_ok;
    c_max = cur[0 +: GREY_W];
    c_min = cur[GREY_W +: GREY_W];
    c_mid = cur[2*GREY_W +: GREY_W];
    c_rng = cur[3*GREY_W +: GREY_W];
    c_dat = cur[4*GREY_W +: W];
    c_par = cur[4*GREY_W+W +: W];
    n_max = c_max;
    n_min = c_min;
    n_mid = c_mid;
    n_rng = c_rng;
    n_dat = c_dat;
    n_par = c_par;
    bit_val = 1'b0;
    diff = c_max - c_min;
    prod = (GREY_W+FRAC_W)'(diff) * (GREY_W+FRAC_W)'(fraction_i);
    sum  = (GREY_W+2)'(c_min) + (GREY_W+2)'(prod[GREY_W+FRAC_W-1:GREY_W]);
    pos_ok = ({1'b0, e_item_q.pos} < (FRAME_W+1)'(W));
    mask   = pos_ok ? (W'(1) << e_item_q.pos) : '0;
    case (e_item_q.cmd)
      CMD_INIT: begin
        n_max = GREY_MIN;
        n_min = GREY_MAX;
      end
      CMD_HIGH: begin
        if (e_item_q.grey > c_max) n_max = e_item_q.grey;
      end
      CMD_LOW: begin
        if (e_item_q.grey < c_min) n_min = e_item_q.grey;
      end
      CMD_CAL: begin
        if (c_max < c_min) begin
          n_mid = GREY_MAX;
          n_rng = GREY_MIN;
        end else begin
          n_rng = diff;
          n_mid = (sum > (GREY_W+2)'(GREY_MAX)) ? GREY_MAX : sum[GREY_W-1:0];
        end
      end
      CMD_SCAN: begin
        bit_val = (e_item_q.grey > c_mid);
        if (e_item_q.clear) begin
          n_dat = '0;
          n_par = '0;
        end
        if (c_rng > qualifier_i) begin
          if (bit_val) begin
            if (e_item_q.to_data) n_dat = n_dat | mask;
            else n_par = n_par | mask;
          end
        end else begin
          n_dat = '0;
        end
      end
      default: begin
      end
    endcase
    nxt = {n_par, n_dat, n_rng, n_mid, n_min, n_max};
  end

  always_ff @(posedge clk_i) begin
    if (e_fire) begin
      mem[e_addr_q] <= nxt;
    end
    if (queue_pop_o) begin
      rd_data_q <= mem[queue_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (queue_pop_o) begin
      e_valid_q <= 1'b1;
    end else if (e_fire) begin
      e_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (queue_pop_o) begin
      e_item_q     <= queue_item_i;
      e_addr_q     <= queue_addr_i;
      e_byp_q      <= e_fire && (e_addr_q == queue_addr_i);
      e_byp_data_q <= nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_free) begin
      out_valid_o <= e_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_fire) begin
      range_out_o   <= nxt[3*GREY_W +: GREY_W];
      mid_out_o     <= nxt[2*GREY_W +: GREY_W];
      binary_bit_o  <= bit_val;
      pixel_used_o  <= (nxt[3*GREY_W +: GREY_W] > qualifier_i);
      data_word_o   <= OUT_WORD_W'(nxt[4*GREY_W +: W]);
      parity_word_o <= OUT_WORD_W'(nxt[4*GREY_W+W +: W]);
      frame_done_o  <= (e_item_q.cmd == CMD_SCAN) && e_item_q.done;
    end
  end

endmodule

// File: src/structured_light_pixel_threshold_core.sv
// Per-pixel structured-light thresholding: every input transfer names a
// pixel and is one of init, add high, add low, calibrate or scan, and it
// produces exactly one output transfer with the pixel's range, mid
// threshold, scan bit and accumulated data and parity words after the item.
// The block takes one item per clock while in_ready_o is high and returns
// results in input order; an input transfer passes two front stages, one
// queue slot, the memory read and the update stage into the output
// register before its output transfer. Throughput is set by the
// single per-pixel memory, which does one read and one write each cycle;
// back-to-back items on the same pixel are forwarded and need no stall.
// The per-pixel memory is not cleared: a pixel must see init and calibrate
// before its range, mid or words mean anything. Configuration transfers are
// always taken and should only be issued while no item is in flight.
module structured_light_pixel_threshold_core
  import slpt_pkg::*;
#(
  parameter int PIXELS        = DEFAULT_PIXELS,
  parameter int MAX_DATA_BITS = DEFAULT_DATA_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [KIND_W-1:0]      kind_i,
  input  logic [IDX_W-1:0]       pixel_index_i,
  input  logic [GREY_W-1:0]      grey_i,
  input  logic [FRAME_W-1:0]     frame_index_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [GREY_W-1:0]      range_out_o,
  output logic [GREY_W-1:0]      mid_out_o,
  output logic                   binary_bit_o,
  output logic                   pixel_used_o,
  output logic [OUT_WORD_W-1:0]  data_word_o,
  output logic [OUT_WORD_W-1:0]  parity_word_o,
  output logic                   frame_done_o
);

  localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int QW = $bits(slpt_item_t) + AW;

  logic [FRAC_W-1:0] fraction_q;
  logic [QUAL_W-1:0] qualifier_q;
  logic [DFR_W-1:0]  data_fr_q;
  logic [TFR_W-1:0]  total_fr_q;

  logic              push;
  slpt_item_t        push_item;
  logic [AW-1:0]     push_addr;
  logic              pop;
  logic              q_not_empty;
  logic [QCNT_W-1:0] q_count;
  logic [QW-1:0]     q_dout;
  slpt_item_t        head_item;
  logic [AW-1:0]     head_addr;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fraction_q  <= FRACTION_RST;
      qualifier_q <= QUALIFIER_RST;
      data_fr_q   <= DATA_FR_RST;
      total_fr_q  <= TOTAL_FR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FRACTION:  fraction_q  <= cfg_data_i;
        CFG_QUALIFIER: qualifier_q <= cfg_data_i[QUAL_W-1:0];
        CFG_DATA_FR:   data_fr_q   <= cfg_data_i[DFR_W-1:0];
        CFG_TOTAL_FR:  total_fr_q  <= cfg_data_i[TFR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  slpt_front #(
    .PIXELS (PIXELS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .pixel_index_i  (pixel_index_i),
    .grey_i         (grey_i),
    .frame_index_i  (frame_index_i),
    .data_frames_i  (data_fr_q),
    .total_frames_i (total_fr_q),
    .queue_count_i  (q_count),
    .push_o         (push),
    .push_item_o    (push_item),
    .push_addr_o    (push_addr)
  );

  slpt_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .din_i       ({push_item, push_addr}),
    .pop_i       (pop),
    .dout_o      (q_dout),
    .not_empty_o (q_not_empty),
    .count_o     (q_count)
  );

  assign head_item = q_dout[QW-1:AW];
  assign head_addr = q_dout[AW-1:0];

  slpt_back #(
    .PIXELS        (PIXELS),
    .MAX_DATA_BITS (MAX_DATA_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_valid_i (q_not_empty),
    .queue_pop_o   (pop),
    .queue_item_i  (head_item),
    .queue_addr_i  (head_addr),
    .fraction_i    (fraction_q),
    .qualifier_i   (qualifier_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .range_out_o   (range_out_o),
    .mid_out_o     (mid_out_o),
    .binary_bit_o  (binary_bit_o),
    .pixel_used_o  (pixel_used_o),
    .data_word_o   (data_word_o),
    .parity_word_o (parity_word_o),
    .frame_done_o  (frame_done_o)
  );

endmodule
